>>> sv/freq_offset_averaging_tracker_defines.svh
// ---------------------------------------------------------------------------
// freq_offset_averaging_tracker_defines.svh
// Assertion macros used by the checker file of the offset tracker.
// ---------------------------------------------------------------------------
`ifndef FREQ_OFFSET_AVERAGING_TRACKER_DEFINES_SVH
`define FREQ_OFFSET_AVERAGING_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define FOAT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define FOAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/foat_pkg.sv
// ---------------------------------------------------------------------------
// foat_pkg
// Types and constants of the frequency offset averaging tracker.
// ---------------------------------------------------------------------------
package foat_pkg;

    // Field widths
    localparam int EST_W = 8;
    localparam int OFF_W = 8;

    // Command codes
    localparam logic CMD_SAMPLE    = 1'b0;
    localparam logic CMD_CALIBRATE = 1'b1;

    // Offset clamp limits
    localparam logic signed [OFF_W-1:0] OFFSET_MAX = 8'sd127;
    localparam logic signed [OFF_W-1:0] OFFSET_MIN = -8'sd128;

    // One input word as held in the input register
    typedef struct packed {
        logic                    cmd;
        logic signed [EST_W-1:0] freq_estimate;
    } item_t;

    // Result of processing one word
    typedef struct packed {
        logic                    emit;
        logic signed [OFF_W-1:0] offset_value;
        logic                    from_calibrate;
    } result_t;

endpackage

>>> sv/foat_stream_ifs.sv
// ---------------------------------------------------------------------------
// foat_stream_ifs
// Valid/ready channels for estimate words and offset result words.
// ---------------------------------------------------------------------------
interface foat_item_if;
    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic signed [foat_pkg::EST_W-1:0]   freq_estimate;

    modport source (output valid, output cmd, output freq_estimate, input ready);
    modport sink   (input valid, input cmd, input freq_estimate, output ready);
endinterface

interface foat_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [foat_pkg::OFF_W-1:0]   offset_value;
    logic                                from_calibrate;

    modport source (output valid, output offset_value, output from_calibrate, input ready);
    modport sink   (input valid, input offset_value, input from_calibrate, output ready);
endinterface

>>> sv/foat_div.sv
// ---------------------------------------------------------------------------
// foat_div
// Signed divide of the window sum by the window size, truncating toward
// zero, done as a reciprocal multiply on the magnitude.
// ---------------------------------------------------------------------------
module foat_div #(
    parameter int WINDOW_SIZE = 8,
    parameter int SUM_W       = 11
) (
    input  logic signed [SUM_W-1:0]            sum,
    output logic signed [foat_pkg::OFF_W-1:0]  quotient
);

    localparam int MAG_W   = SUM_W;
    localparam int LOG_W   = $clog2(WINDOW_SIZE);
    localparam int SHIFT   = MAG_W + LOG_W;
    localparam int RECIP_W = MAG_W + 1;
    localparam int PROD_W  = MAG_W + RECIP_W;
    // ceil(2^SHIFT / WINDOW_SIZE) gives an exact floor for any magnitude below 2^MAG_W
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((longint'(1) << SHIFT) + WINDOW_SIZE - 1) / WINDOW_SIZE);

    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [PROD_W-1:0] prod;
    logic [foat_pkg::OFF_W-1:0] q_mag;

    // Take the magnitude, scale by the reciprocal, restore the sign
    always_comb
    begin
        neg      = sum[SUM_W-1];
        mag      = neg ? MAG_W'(-sum) : MAG_W'(sum);
        prod     = PROD_W'(mag) * PROD_W'(RECIP);
        q_mag    = foat_pkg::OFF_W'(prod >> SHIFT);
        quotient = neg ? signed'(-q_mag) : signed'(q_mag);
    end

endmodule

>>> sv/foat_track.sv
// ---------------------------------------------------------------------------
// foat_track
// Window accumulator and offset state; computes the result of one word.
// ---------------------------------------------------------------------------
module foat_track #(
    parameter int WINDOW_SIZE = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  foat_pkg::item_t   item,
    output foat_pkg::result_t result
);

    localparam int SUM_W = $clog2(WINDOW_SIZE * 128) + 1;
    localparam int CNT_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(WINDOW_SIZE - 1);
    localparam int OSUM_W = foat_pkg::OFF_W + 1;

    logic signed [SUM_W-1:0]           sum_reg, sum_next;
    logic [CNT_W-1:0]                  count_reg, count_next;
    logic signed [foat_pkg::OFF_W-1:0] offset_reg, offset_next;

    logic signed [SUM_W-1:0]           sum_add;
    logic signed [foat_pkg::OFF_W-1:0] avg;
    logic signed [OSUM_W-1:0]          off_sum;
    logic signed [foat_pkg::OFF_W-1:0] off_clamped;
    logic                              is_cal;
    logic                              window_done;

    // Divide the completed window sum
    foat_div #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .SUM_W       (SUM_W)
    ) u_div (
        .sum      (sum_add),
        .quotient (avg)
    );

    // Accumulate, average and clamp
    always_comb
    begin
        is_cal      = (item.cmd == foat_pkg::CMD_CALIBRATE);
        sum_add     = sum_reg + SUM_W'(item.freq_estimate);
        window_done = !is_cal && (count_reg == LAST);
        off_sum     = OSUM_W'(offset_reg) + OSUM_W'(avg);
        if (off_sum >= OSUM_W'(foat_pkg::OFFSET_MAX))
            off_clamped = foat_pkg::OFFSET_MAX;
        else if (off_sum <= OSUM_W'(foat_pkg::OFFSET_MIN))
            off_clamped = foat_pkg::OFFSET_MIN;
        else
            off_clamped = foat_pkg::OFF_W'(off_sum);

        sum_next    = sum_reg;
        count_next  = count_reg;
        offset_next = offset_reg;
        if (is_cal)
        begin
            offset_next = '0;
        end
        else if (window_done)
        begin
            sum_next    = '0;
            count_next  = '0;
            offset_next = off_clamped;
        end
        else
        begin
            sum_next   = sum_add;
            count_next = count_reg + CNT_W'(1);
        end

        result.emit           = is_cal || window_done;
        result.offset_value   = is_cal ? '0 : off_clamped;
        result.from_calibrate = is_cal;
    end

    // Update state when the held word is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            count_reg  <= '0;
            offset_reg <= '0;
        end
        else if (advance)
        begin
            sum_reg    <= sum_next;
            count_reg  <= count_next;
            offset_reg <= offset_next;
        end
    end

endmodule

>>> sv/freq_offset_averaging_tracker.sv
// ---------------------------------------------------------------------------
// freq_offset_averaging_tracker
// Averages frequency-error estimates over fixed windows and tracks a
// clamped offset; a calibrate word clears the offset.
// ---------------------------------------------------------------------------
// Path: a word accepted into the input register reaches the result register
//   when it advances; no result for a sample word that ends no window.
// Throughput: one word per cycle unless result backpressure stalls it; the
//   accumulate, divide and clamp fit in the single stage between the input
//   and result registers.
// Reset: rst_n clears the window sum, sample count, offset and both valids.
// ---------------------------------------------------------------------------
module freq_offset_averaging_tracker #(
    parameter int WINDOW_SIZE = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    foat_item_if.sink            item,
    foat_result_if.source        result
);

    logic              stage_valid_reg, stage_valid_next;
    foat_pkg::item_t   stage_item_reg;
    logic              out_valid_reg, out_valid_next;
    foat_pkg::result_t out_res_reg;
    foat_pkg::result_t calc;
    logic              out_free;
    logic              advance;
    logic              take;

    // Process the held word
    foat_track #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_track (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (stage_item_reg),
        .result  (calc)
    );

    // Handshake control
    always_comb
    begin
        out_free   = !out_valid_reg || result.ready;
        advance    = stage_valid_reg && out_free;
        item.ready = !stage_valid_reg || out_free;
        take       = item.valid && item.ready;

        stage_valid_next = take ? 1'b1 : (advance ? 1'b0 : stage_valid_reg);
        if (advance && calc.emit)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Load input and result words
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_item_reg.cmd           <= item.cmd;
            stage_item_reg.freq_estimate <= item.freq_estimate;
        end
        if (advance && calc.emit)
            out_res_reg <= calc;
    end

    assign result.valid          = out_valid_reg;
    assign result.offset_value   = out_res_reg.offset_value;
    assign result.from_calibrate = out_res_reg.from_calibrate;

endmodule

>>> sv/foat_chk.sv
// ---------------------------------------------------------------------------
// foat_chk
// Port-level checks of the offset tracker, bound to its top level.
// ---------------------------------------------------------------------------
`include "freq_offset_averaging_tracker_defines.svh"

module foat_chk (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               item_valid,
    input logic                               item_ready,
    input logic                               result_valid,
    input logic                               result_ready,
    input logic signed [foat_pkg::OFF_W-1:0]  offset_value,
    input logic                               from_calibrate
);

    // Calibrate results always carry a zero offset
    `FOAT_ASSERT_IMPL(a_cal_zero, clk, rst_n, result_valid && from_calibrate, offset_value == '0, "calibrate result with nonzero offset")

    // Input stalls only behind a blocked result
    `FOAT_ASSERT_IMPL(a_stall_cause, clk, rst_n, !item_ready, result_valid && !result_ready, "input stalled without output backpressure")

    // Drop no pending result under backpressure
    `FOAT_ASSERT_NEXT(a_hold_valid, clk, rst_n, result_valid && !result_ready, result_valid && $stable(offset_value) && $stable(from_calibrate), "pending result changed or dropped")

    // Idle output side never stalls input
    `FOAT_ASSERT_IMPL(a_ready_idle, clk, rst_n, !result_valid && item_valid, item_ready, "input not ready while output empty")

endmodule

bind freq_offset_averaging_tracker foat_chk u_foat_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item.valid),
    .item_ready     (item.ready),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .offset_value   (result.offset_value),
    .from_calibrate (result.from_calibrate)
);

>>> dv/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Drives estimate and calibrate words into the frequency offset tracker,
// predicts each windowed offset update and calibrate reply, and compares
// every result word against the oldest prediction, under several idle and
// stall patterns on both channels.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AVG_WINDOW      = 8;
    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 5;
    localparam int SETTLE_CYCLES   = 8;
    localparam int CYCLE_LIMIT     = 100000;
    localparam int ITEMS_PER_PHASE = 350;
    localparam int CALIBRATE_PCT   = 6;

    localparam logic signed [foat_pkg::EST_W-1:0] EST_HI = 8'sh7f;
    localparam logic signed [foat_pkg::EST_W-1:0] EST_LO = 8'sh80;

    typedef struct packed {
        logic signed [foat_pkg::OFF_W-1:0] offset_value;
        logic                              from_calibrate;
    } offset_word_t;

    logic clk;
    logic rst_n;

    foat_item_if   item_ch ();
    foat_result_if result_ch ();

    freq_offset_averaging_tracker #(
        .WINDOW_SIZE(AVG_WINDOW)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item(item_ch),
        .result(result_ch)
    );

    // Tracker state as predicted from accepted words
    int est_sum        = 0;
    int est_count      = 0;
    int tracked_offset = 0;

    offset_word_t pending_offsets[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int tx_gap_pct     = 0;
    int rx_stall_pct   = 0;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Print one mismatch line and count it
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Advance the predicted tracker by one accepted word; return 1 when a
    // result word is due
    function automatic bit advance_tracker(input logic cmd,
                                           input logic signed [foat_pkg::EST_W-1:0] est,
                                           output offset_word_t word);
        int avg;
        int next_offset;
        word = '0;
        if (cmd == foat_pkg::CMD_CALIBRATE)
        begin
            tracked_offset      = 0;
            word.from_calibrate = 1'b1;
            return 1'b1;
        end
        est_sum   = est_sum + est;
        est_count = est_count + 1;
        if (est_count < AVG_WINDOW)
            return 1'b0;
        // Divide truncates toward zero for signed int operands
        avg       = est_sum / AVG_WINDOW;
        est_sum   = 0;
        est_count = 0;
        next_offset = tracked_offset + avg;
        if (next_offset >= foat_pkg::OFFSET_MAX)
            next_offset = foat_pkg::OFFSET_MAX;
        if (next_offset <= foat_pkg::OFFSET_MIN)
            next_offset = foat_pkg::OFFSET_MIN;
        tracked_offset      = next_offset;
        word.offset_value   = next_offset[foat_pkg::OFF_W-1:0];
        word.from_calibrate = 1'b0;
        return 1'b1;
    endfunction

    // Send one word; entered and left just after a falling edge
    task automatic send_word(input logic cmd,
                             input logic signed [foat_pkg::EST_W-1:0] est);
        offset_word_t word;
        // Hold off with junk payload while idle
        while ($urandom_range(99) < tx_gap_pct)
        begin
            item_ch.valid         <= 1'b0;
            item_ch.cmd           <= 1'($urandom);
            item_ch.freq_estimate <= 8'($urandom);
            @(negedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.cmd           <= cmd;
        item_ch.freq_estimate <= est;
        do
            @(posedge clk);
        while (!item_ch.ready);
        if (advance_tracker(cmd, est, word))
            pending_offsets.push_back(word);
        @(negedge clk);
    endtask

    // Drop valid and hold until every predicted word has arrived
    task automatic pause_until_drained();
        item_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_offsets.size() != 0);
    endtask

    // Calibrate mid-window keeps the partial sum; the sum -9 averages to -1
    task automatic test_calibrate_mid_window();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        send_word(foat_pkg::CMD_CALIBRATE, EST_LO);
        send_word(foat_pkg::CMD_SAMPLE, EST_HI);
        send_word(foat_pkg::CMD_SAMPLE, EST_LO);
        send_word(foat_pkg::CMD_SAMPLE, -8'sd8);
        send_word(foat_pkg::CMD_CALIBRATE, EST_HI);
        repeat (AVG_WINDOW - 3)
            send_word(foat_pkg::CMD_SAMPLE, 8'sd0);
    endtask

    // Full window of minimum estimates drives the offset past the low clamp
    task automatic test_offset_saturation();
        repeat (AVG_WINDOW)
            send_word(foat_pkg::CMD_SAMPLE, EST_LO);
    endtask

    // Random windows with a per-window bias, sprinkled with calibrates
    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
        logic signed [foat_pkg::EST_W-1:0] est;
        int bias;
        tx_gap_pct   = tx_pct;
        rx_stall_pct = rx_pct;
        bias         = 0;
        repeat (count)
        begin
            if ($urandom_range(99) < CALIBRATE_PCT)
                send_word(foat_pkg::CMD_CALIBRATE, 8'($urandom));
            else
            begin
                if (est_count == 0)
                    bias = $urandom_range(4);
                case (bias)
                    0:       est = 8'($urandom);
                    1:       est = 8'($urandom_range(127, 64));
                    2:       est = 8'(int'($urandom_range(64)) - 128);
                    3:       est = 8'(int'($urandom_range(16)) - 8);
                    default: est = $urandom_range(1) ? EST_HI : EST_LO;
                endcase
                send_word(foat_pkg::CMD_SAMPLE, est);
            end
        end
    endtask

    // Drive result ready, stalling at the current rate
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Compare each accepted result word with the oldest prediction
    always @(posedge clk)
    begin : check_results
        offset_word_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_offsets.size() == 0)
                report_mismatch($sformatf("unexpected word offset=%0d from_calibrate=%0b",
                                          result_ch.offset_value, result_ch.from_calibrate));
            else
            begin
                want = pending_offsets.pop_front();
                if (result_ch.offset_value !== want.offset_value)
                    report_mismatch($sformatf("offset_value got %0d want %0d",
                                              result_ch.offset_value, want.offset_value));
                if (result_ch.from_calibrate !== want.from_calibrate)
                    report_mismatch($sformatf("from_calibrate got %0b want %0b",
                                              result_ch.from_calibrate, want.from_calibrate));
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        item_ch.valid         = 1'b0;
        item_ch.cmd           = foat_pkg::CMD_SAMPLE;
        item_ch.freq_estimate = '0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_calibrate_mid_window();
        test_offset_saturation();
        pause_until_drained();

        test_random_traffic(0, 0, ITEMS_PER_PHASE);
        pause_until_drained();
        test_random_traffic(55, 0, ITEMS_PER_PHASE);
        test_random_traffic(0, 55, ITEMS_PER_PHASE);
        pause_until_drained();
        test_random_traffic(8, 8, ITEMS_PER_PHASE);
        pause_until_drained();

        // Let any stray word show up before the verdict
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/foat_pkg.sv
sv/foat_stream_ifs.sv
sv/foat_div.sv
sv/foat_track.sv
sv/freq_offset_averaging_tracker.sv
sv/foat_chk.sv
dv/testbench.sv
